/* sv/nfba_pkg.sv */
// Package for the next-fit block allocator: sizes, register map, beat types
// and the controller state type. No dependencies.
package nfba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int SIZE_BITS  = 16;
    localparam int INDEX_W    = 5;
    localparam int COUNT_W    = 6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register index as decoded from paddr[CFG_ADDR_W-1:2].
    localparam logic [CFG_ADDR_W-3:0] REG_BLOCK_COUNT = 1'b0;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 6'd32;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 opcode;
        logic [INDEX_W-1:0]   block_index;
        logic [SIZE_BITS-1:0] block_size_in;
        logic [SIZE_BITS-1:0] request_size;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [INDEX_W-1:0]   chosen_block;
        logic [SIZE_BITS-1:0] chosen_size;
        logic [SIZE_BITS-1:0] fragment;
    } out_item_t;

endpackage

/* sv/nfba_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/next_fit_block_allocator.sv */
// Next-fit block allocator: size table in RAM, circular scan controller,
// APB register for the block count. Depends on nfba_pkg and nfba_ram.
//
//   Channel   Direction  Handshake              Beat contents
//   in        sink       in_valid / in_ready    nfba_pkg::in_item_t
//   out       source     out_valid / out_ready  nfba_pkg::out_item_t
//   apb       slave      psel/penable/pready    block_count at byte address 0
//
// A load beat writes the table directly. A request beat scans at most the n
// blocks in use, stopping at the first that fits: the size table has one
// read port, so the scan examines one block per cycle.
// The table is not cleared at reset; it must be loaded before it is searched.
// Input is held off from acceptance of a request until its result has moved
// into the output register, which frees only when the previous beat is taken.
module next_fit_block_allocator #(
    parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  nfba_pkg::in_item_t                   in_data,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output nfba_pkg::out_item_t                  out_data,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nfba_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [nfba_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [nfba_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int NW = (CW > nfba_pkg::COUNT_W) ? CW : nfba_pkg::COUNT_W;
    localparam int SB = nfba_pkg::SIZE_BITS;

    nfba_pkg::state_t              state_reg, state_next;
    logic [nfba_pkg::COUNT_W-1:0]  block_count_reg, block_count_next;
    logic [IW-1:0]                 next_start_reg, next_start_next;
    logic                          out_valid_reg, out_valid_next;
    nfba_pkg::out_item_t           out_data_reg, out_data_next;

    logic [CW-1:0]                 n_reg, n_next;
    logic [SB-1:0]                 req_reg, req_next;
    logic [IW-1:0]                 pos_reg, pos_next;
    logic [IW-1:0]                 chk_pos_reg, chk_pos_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          res_found_reg, res_found_next;
    logic [IW-1:0]                 res_pos_reg, res_pos_next;
    logic [SB-1:0]                 res_size_reg, res_size_next;
    logic [SB-1:0]                 res_frag_reg, res_frag_next;

    logic [NW-1:0]                 bc_ext;
    logic [NW-1:0]                 max_ext;
    logic [CW-1:0]                 n_now;
    logic [IW-1:0]                 start_pos;
    logic [CW:0]                   start_inc;
    logic [IW-1:0]                 start_wrap;
    logic [CW:0]                   pos_inc;
    logic [IW-1:0]                 pos_wrap;
    logic [CW:0]                   chk_inc;
    logic [IW-1:0]                 chk_wrap;

    logic                          in_fire;
    logic                          req_take;
    logic                          load_take;
    logic                          hit;
    logic                          last;
    logic                          emit_free;
    logic                          cfg_write;
    logic                          cfg_sel_count;

    logic                          ram_wr_en;
    logic [IW-1:0]                 ram_wr_addr;
    logic [IW-1:0]                 ram_rd_addr;
    logic [SB-1:0]                 ram_rd_data;

    nfba_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_BLOCKS)
    ) u_size_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_data.block_size_in),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Blocks in use, saturated at the table depth.
    assign bc_ext  = NW'(block_count_reg);
    assign max_ext = NW'(MAX_BLOCKS);
    assign n_now   = CW'((bc_ext > max_ext) ? max_ext : bc_ext);

    // A start pointer left beyond a lowered block count restarts at block 0.
    assign start_pos  = ((CW + 1)'(next_start_reg) < (CW + 1)'(n_now)) ? next_start_reg : '0;
    assign start_inc  = (CW + 1)'(start_pos) + (CW + 1)'(1);
    assign start_wrap = (start_inc < (CW + 1)'(n_now)) ? IW'(start_inc) : '0;

    assign pos_inc  = (CW + 1)'(pos_reg) + (CW + 1)'(1);
    assign pos_wrap = (pos_inc < (CW + 1)'(n_reg)) ? IW'(pos_inc) : '0;
    assign chk_inc  = (CW + 1)'(chk_pos_reg) + (CW + 1)'(1);
    assign chk_wrap = (chk_inc < (CW + 1)'(n_reg)) ? IW'(chk_inc) : '0;

    assign in_ready  = (state_reg == nfba_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign req_take  = in_fire && (in_data.opcode == nfba_pkg::OP_REQUEST);
    assign load_take = in_fire && (in_data.opcode == nfba_pkg::OP_LOAD);

    // Read data always belongs to the block at chk_pos_reg during the scan.
    assign hit       = (ram_rd_data >= req_reg);
    assign last      = (cnt_reg == n_reg);
    assign emit_free = !out_valid_reg || out_ready;

    assign cfg_sel_count = (paddr[nfba_pkg::CFG_ADDR_W-1:2] == nfba_pkg::REG_BLOCK_COUNT);
    assign cfg_write     = psel && penable && pwrite && pready;

    assign pready    = 1'b1;
    assign prdata    = cfg_sel_count ? nfba_pkg::CFG_DATA_W'(block_count_reg) : '0;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfba_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = (n_now == '0) ? nfba_pkg::ST_EMIT : nfba_pkg::ST_SCAN;
                end
            end
            nfba_pkg::ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = nfba_pkg::ST_EMIT;
                end
            end
            nfba_pkg::ST_EMIT:
            begin
                if (emit_free)
                begin
                    state_next = nfba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfba_pkg::ST_IDLE;
            end
        endcase
    end

    // Table access, scan datapath and output register.
    always_comb
    begin
        ram_wr_en        = load_take && (32'(in_data.block_index) < MAX_BLOCKS);
        ram_wr_addr      = IW'(in_data.block_index);
        ram_rd_addr      = pos_reg;

        block_count_next = block_count_reg;
        next_start_next  = next_start_reg;
        n_next           = n_reg;
        req_next         = req_reg;
        pos_next         = pos_reg;
        chk_pos_next     = chk_pos_reg;
        cnt_next         = cnt_reg;
        res_found_next   = res_found_reg;
        res_pos_next     = res_pos_reg;
        res_size_next    = res_size_reg;
        res_frag_next    = res_frag_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cfg_write && cfg_sel_count)
        begin
            block_count_next = pwdata[nfba_pkg::COUNT_W-1:0];
        end

        unique case (state_reg)
            nfba_pkg::ST_IDLE:
            begin
                ram_rd_addr = start_pos;
                if (req_take)
                begin
                    req_next       = SB'(in_data.request_size);
                    n_next         = n_now;
                    chk_pos_next   = start_pos;
                    pos_next       = start_wrap;
                    cnt_next       = CW'(1);
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_size_next  = '0;
                    res_frag_next  = '0;
                end
            end
            nfba_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_found_next  = 1'b1;
                    res_pos_next    = chk_pos_reg;
                    res_size_next   = ram_rd_data;
                    res_frag_next   = ram_rd_data - req_reg;
                    next_start_next = chk_wrap;
                end
                else if (!last)
                begin
                    chk_pos_next = pos_reg;
                    pos_next     = pos_wrap;
                    cnt_next     = cnt_reg + CW'(1);
                end
            end
            nfba_pkg::ST_EMIT:
            begin
                if (emit_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.found        = res_found_reg;
                    out_data_next.chosen_block = nfba_pkg::INDEX_W'(res_pos_reg);
                    out_data_next.chosen_size  = res_size_reg;
                    out_data_next.fragment     = res_frag_reg;
                end
            end
            default:
            begin
                ram_rd_addr = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nfba_pkg::ST_IDLE;
            block_count_reg <= nfba_pkg::BLOCK_COUNT_RESET;
            next_start_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            block_count_reg <= block_count_next;
            next_start_reg  <= next_start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        req_reg       <= req_next;
        pos_reg       <= pos_next;
        chk_pos_reg   <= chk_pos_next;
        cnt_reg       <= cnt_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_size_reg  <= res_size_next;
        res_frag_reg  <= res_frag_next;
        out_data_reg  <= out_data_next;
    end

endmodule

/* bench/next_fit_block_allocator_tb.sv */
// Self-checking testbench for the next-fit block allocator: drives load and
// request beats, predicts every placement and checks each result beat.
// Depends on nfba_pkg and the next_fit_block_allocator RTL.
module next_fit_block_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 40;
    localparam int HOLD_TICKS   = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    nfba_pkg::in_item_t   in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    nfba_pkg::out_item_t  out_data;

    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [nfba_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [nfba_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [nfba_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    // Shadow of the allocator state.
    logic [nfba_pkg::SIZE_BITS-1:0] size_shadow [nfba_pkg::MAX_BLOCKS];
    logic [nfba_pkg::INDEX_W-1:0]   rover_shadow = '0;
    logic [nfba_pkg::COUNT_W-1:0]   count_shadow = nfba_pkg::BLOCK_COUNT_RESET;

    nfba_pkg::in_item_t  pending_beats [$];
    nfba_pkg::out_item_t expected_placements [$];
    nfba_pkg::out_item_t predicted;
    nfba_pkg::out_item_t oldest;

    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_off  = 1'b0;

    int unsigned error_count = 0;
    int unsigned cycles      = 0;
    int unsigned loads_taken = 0;
    int unsigned reqs_taken  = 0;
    int unsigned placed      = 0;
    int unsigned missed      = 0;
    int unsigned settings    = 0;

    next_fit_block_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Applies one accepted beat to the shadow state; returns 1 when a result
    // beat is due, with its contents in placement.
    function automatic bit predict_placement(input nfba_pkg::in_item_t beat,
                                             output nfba_pkg::out_item_t placement);
        int unsigned span;
        int unsigned pos;
        placement = '0;
        if (beat.opcode == nfba_pkg::OP_LOAD)
        begin
            size_shadow[beat.block_index] = beat.block_size_in;
            return 1'b0;
        end
        span = (count_shadow > nfba_pkg::MAX_BLOCKS) ? nfba_pkg::MAX_BLOCKS : count_shadow;
        pos  = (rover_shadow < span) ? rover_shadow : 0;
        for (int k = 0; k < span; k++)
        begin
            if (size_shadow[pos] >= beat.request_size)
            begin
                placement.found        = 1'b1;
                placement.chosen_block = pos[nfba_pkg::INDEX_W-1:0];
                placement.chosen_size  = size_shadow[pos];
                placement.fragment     = size_shadow[pos] - beat.request_size;
                rover_shadow = nfba_pkg::INDEX_W'((pos + 1 < span) ? pos + 1 : 0);
                return 1'b1;
            end
            pos = (pos + 1 < span) ? pos + 1 : 0;
        end
        return 1'b1;
    endfunction

    // Sizes drawn from several bands so that fits and misses both occur often.
    function automatic logic [nfba_pkg::SIZE_BITS-1:0] pick_size();
        case ($urandom_range(3))
            0: return nfba_pkg::SIZE_BITS'($urandom);
            1: return nfba_pkg::SIZE_BITS'($urandom_range(255));
            2: return nfba_pkg::SIZE_BITS'(16'hFFFF - $urandom_range(15));
            default: return nfba_pkg::SIZE_BITS'($urandom_range(4095));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Input driver: offers the queued beats, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.opcode == nfba_pkg::OP_LOAD)
                    loads_taken++;
                else
                    reqs_taken++;
                if (predict_placement(in_data, predicted))
                    expected_placements.push_back(predicted);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_placements.size() == 0)
                begin
                    $error("result beat with nothing expected: found=%0d block=%0d size=%0d",
                           out_data.found, out_data.chosen_block, out_data.chosen_size);
                    error_count++;
                end
                else
                begin
                    oldest = expected_placements.pop_front();
                    check_field("found", 32'(oldest.found), 32'(out_data.found));
                    check_field("chosen_block", 32'(oldest.chosen_block),
                                32'(out_data.chosen_block));
                    check_field("chosen_size", 32'(oldest.chosen_size),
                                32'(out_data.chosen_size));
                    check_field("fragment", 32'(oldest.fragment), 32'(out_data.fragment));
                    if (oldest.found)
                        placed++;
                    else
                        missed++;
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_load(input int unsigned idx, input int unsigned size);
        nfba_pkg::in_item_t beat;
        beat.opcode        = nfba_pkg::OP_LOAD;
        beat.block_index   = nfba_pkg::INDEX_W'(idx);
        beat.block_size_in = nfba_pkg::SIZE_BITS'(size);
        beat.request_size  = nfba_pkg::SIZE_BITS'($urandom);
        pending_beats.push_back(beat);
    endtask

    task automatic push_request(input int unsigned size);
        nfba_pkg::in_item_t beat;
        beat.opcode        = nfba_pkg::OP_REQUEST;
        beat.block_index   = nfba_pkg::INDEX_W'($urandom);
        beat.block_size_in = nfba_pkg::SIZE_BITS'($urandom);
        beat.request_size  = nfba_pkg::SIZE_BITS'(size);
        pending_beats.push_back(beat);
    endtask

    // Waits until the block is idle, then writes the block count register.
    // The idle test is made at the falling edge, once the driver's updates
    // of the rising edge have settled.
    task automatic set_block_count(input int unsigned value);
        while (pending_beats.size() != 0 || in_valid || expected_placements.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {nfba_pkg::REG_BLOCK_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_shadow = value[nfba_pkg::COUNT_W-1:0];
        settings++;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned counts [11] = '{32, 63, 3, 33, 1, 17, 0, 8, 32, 2, 24};
        int unsigned idle_set [4] = '{0, 83, 0, 9};
        int unsigned stall_set [4] = '{0, 0, 83, 9};
        nfba_pkg::in_item_t beat;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: a four-block table with the size extremes.
        set_block_count(4);
        push_load(0, 0);
        push_load(1, 16'hFFFF);
        push_load(2, 100);
        push_load(3, 7);
        push_load(31, 16'hFFFF);
        push_request(0);           // zero size takes the first block scanned
        push_request(16'hFFFF);
        push_request(16'hFFFF);    // wraps round to the same block
        push_request(101);
        push_request(7);
        push_request(8);
        push_load(1, 16'hFFFE);
        push_request(16'hFFFF);    // nothing fits, so the rover stays put
        push_request(16'hFFFE);
        // The rover now lies beyond the new count, so the scan restarts at 0.
        set_block_count(2);
        push_request(50);
        set_block_count(0);
        push_request(0);
        push_request(16'hFFFF);
        set_block_count(1);
        push_request(0);
        push_request(1);

        // Random part: fill the whole table, then sweep the counts.
        for (int i = 0; i < nfba_pkg::MAX_BLOCKS; i++)
            push_load(i, pick_size());
        for (int p = 0; p < $size(counts); p++)
        begin
            set_block_count(counts[p]);
            idle_pct  = idle_set[p % 4];
            stall_pct = stall_set[p % 4];
            if (p == 0)
            begin
                // Long receiver hold-off while beats keep coming.
                fork
                    begin
                        @(posedge clk);
                        hold_off <= 1'b1;
                        repeat (HOLD_TICKS) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 45; i++)
            begin
                beat.opcode        = ($urandom_range(3) == 0) ? nfba_pkg::OP_LOAD
                                                              : nfba_pkg::OP_REQUEST;
                beat.block_index   = nfba_pkg::INDEX_W'($urandom_range(nfba_pkg::MAX_BLOCKS - 1));
                beat.block_size_in = pick_size();
                beat.request_size  = pick_size();
                pending_beats.push_back(beat);
            end
        end

        while (pending_beats.size() != 0 || in_valid || expected_placements.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (expected_placements.size() != 0)
        begin
            $error("%0d placements never arrived", expected_placements.size());
            error_count++;
        end

        $display("Ran %0d loads and %0d requests over %0d block-count settings.",
                 loads_taken, reqs_taken, settings);
        $display("Requests placed: %0d, not placed: %0d; mismatches: %0d.",
                 placed, missed, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/nfba_pkg.sv
sv/nfba_ram.sv
sv/next_fit_block_allocator.sv
bench/next_fit_block_allocator_tb.sv
